### rtl/core/yuyv_pkg.sv
`default_nettype none
package yuyv_pkg;

  localparam int BLOCK_WORDS      = 96;
  localparam int CHROMA_WORDS     = 32;
  localparam int LUMA_WORDS       = 64;
  localparam int WRITES_PER_BLOCK = 64;
  localparam int WORD_IDX_BITS    = 7;
  localparam int BASE_BITS        = 23;
  localparam int CFG_INDEX_BITS   = 2;
  localparam int CFG_DATA_BITS    = 23;
  localparam int GEOM_BITS        = 6;
  localparam int COUNT_BITS       = 13;
  localparam int TILE_OFS_BITS    = 22;
  localparam int STRIDE_BITS      = 12;
  localparam int TILE_STRIDE      = 32;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TEXTURE_BASE  = 2'd0,
    REG_BLOCKS_ACROSS = 2'd1,
    REG_BLOCKS_DOWN   = 2'd2,
    REG_SINGLE_TILE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                     bank;
    logic [TILE_OFS_BITS-1:0] offset;
    logic [STRIDE_BITS-1:0]   stride;
    logic [COUNT_BITS-1:0]    blocks_done;
    logic                     done;
  } job_t;

  typedef struct packed {
    logic        we;
    logic        luma;
    logic        bank;
    logic [5:0]  addr;
    logic [31:0] data;
  } mem_wr_t;

endpackage
`default_nettype wire

### rtl/core/yuv420_macroblock_to_yuyv.sv
`default_nettype none
// YUV 4:2:0 macroblock to YUYV converter. Takes one 32-bit stream word per cycle while
// full is low; every 96 words (U plane, V plane, four Y quadrants) form a macroblock
// that comes out as 64 eight-byte VRAM writes, one per cycle while the output FIFO has
// room, after a job load, so a block is written while the next one is being received. The
// block store holds two macroblocks; full rises only while both hold blocks whose writes
// have not all been issued, which happens when results are not popped. The first write
// of a block passes through the job queue, job load, read registers and output FIFO. The
// store needs no clearing pass. Writing texture_base restarts the tile position and the
// block count; configuration must be written only while the converter is idle (unchecked).
module yuv420_macroblock_to_yuyv import yuyv_pkg::*; #(
  parameter int VRAM_ADDR_BITS = 23
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      push,
  output logic                      full,
  input  logic [31:0]               in_stream_word,
  output logic                      empty,
  input  logic                      pop,
  output logic [VRAM_ADDR_BITS-1:0] out_vram_address,
  output logic [63:0]               out_pixel_pair_data,
  output logic                      out_last_of_block,
  output logic                      out_texture_done,
  output logic [COUNT_BITS-1:0]     out_blocks_done
);

  logic                 q_full;
  logic                 q_push;
  job_t                 q_job;
  logic                 q_valid;
  job_t                 q_head;
  logic                 q_pop;
  mem_wr_t              mem_wr;
  logic [BASE_BITS-1:0] texture_base;

  yuyv_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .stream_word  (in_stream_word),
    .full         (full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job),
    .mem_wr       (mem_wr),
    .texture_base (texture_base)
  );

  yuyv_jobq u_jobq (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_job   (q_job),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  yuyv_back #(
    .VRAM_ADDR_BITS (VRAM_ADDR_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mem_wr          (mem_wr),
    .texture_base    (texture_base),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .vram_address    (out_vram_address),
    .pixel_pair_data (out_pixel_pair_data),
    .last_of_block   (out_last_of_block),
    .texture_done    (out_texture_done),
    .blocks_done     (out_blocks_done)
  );

endmodule
`default_nettype wire

### rtl/core/yuyv_front.sv
`default_nettype none
module yuyv_front import yuyv_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      push,
  input  logic [31:0]               stream_word,
  output logic                      full,
  input  logic                      q_full,
  output logic                      q_push,
  output job_t                      q_job,
  output mem_wr_t                   mem_wr,
  output logic [BASE_BITS-1:0]      texture_base
);

  logic [BASE_BITS-1:0]     base_r, base_nxt;
  logic [GEOM_BITS-1:0]     across_m1_r, across_m1_nxt;
  logic [GEOM_BITS-1:0]     down_m1_r, down_m1_nxt;
  logic                     single_r, single_nxt;
  logic [WORD_IDX_BITS-1:0] word_idx_r, word_idx_nxt;
  logic [GEOM_BITS-1:0]     col_r, col_nxt;
  logic [GEOM_BITS-1:0]     row_r, row_nxt;
  logic [COUNT_BITS-1:0]    dcount_r, dcount_nxt;
  logic                     bank_r, bank_nxt;

  logic                     accept;
  logic                     last_word;
  logic [GEOM_BITS:0]       across;
  logic [GEOM_BITS:0]       down;
  logic [13:0]              total;
  logic [COUNT_BITS-1:0]    dcount_inc;
  logic                     done;
  logic [GEOM_BITS-1:0]     col_eff;
  logic [GEOM_BITS-1:0]     row_eff;
  logic [GEOM_BITS:0]       col_inc;
  logic [GEOM_BITS:0]       row_inc;
  logic [COUNT_BITS-1:0]    row_mul;
  logic [WORD_IDX_BITS-1:0] luma_idx;

  assign accept    = push & ~q_full;
  assign full      = q_full;
  assign last_word = (word_idx_r == WORD_IDX_BITS'(BLOCK_WORDS - 1));

  assign across     = {1'b0, across_m1_r} + 7'd1;
  assign down       = {1'b0, down_m1_r} + 7'd1;
  assign total      = 14'(across) * 14'(down);
  assign dcount_inc = dcount_r + 13'd1;
  assign done       = ({1'b0, dcount_inc} >= total);

  assign col_eff = ({1'b0, col_r} >= across) ? '0 : col_r;
  assign row_eff = ({1'b0, row_r} >= down) ? '0 : row_r;
  assign col_inc = {1'b0, col_eff} + 7'd1;
  assign row_inc = {1'b0, row_eff} + 7'd1;
  assign row_mul = 13'(row_eff) * 13'(across);

  assign luma_idx = word_idx_r - WORD_IDX_BITS'(CHROMA_WORDS);

  always_comb begin
    mem_wr.we   = accept;
    mem_wr.bank = bank_r;
    mem_wr.data = stream_word;
    mem_wr.luma = (word_idx_r >= WORD_IDX_BITS'(CHROMA_WORDS));
    mem_wr.addr = mem_wr.luma ? luma_idx[5:0] : {1'b0, word_idx_r[4:0]};
  end

  always_comb begin
    q_push            = accept & last_word;
    q_job.bank        = bank_r;
    q_job.blocks_done = dcount_inc;
    q_job.done        = done;
    if (single_r) begin
      q_job.offset = '0;
      q_job.stride = STRIDE_BITS'(TILE_STRIDE);
    end else begin
      q_job.offset = {row_mul, 9'b0} + TILE_OFS_BITS'({col_eff, 5'b0});
      q_job.stride = {across, 5'b0};
    end
  end

  assign texture_base = base_r;

  always_comb begin
    base_nxt      = base_r;
    across_m1_nxt = across_m1_r;
    down_m1_nxt   = down_m1_r;
    single_nxt    = single_r;
    word_idx_nxt  = word_idx_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    dcount_nxt    = dcount_r;
    bank_nxt      = bank_r;

    if (accept) begin
      if (last_word) begin
        word_idx_nxt = '0;
        bank_nxt     = ~bank_r;
        dcount_nxt   = dcount_inc;
        if (!single_r) begin
          if (col_inc >= across) begin
            col_nxt = '0;
            row_nxt = (row_inc >= down) ? '0 : row_inc[GEOM_BITS-1:0];
          end else begin
            col_nxt = col_inc[GEOM_BITS-1:0];
            row_nxt = row_eff;
          end
        end
        if (done) begin
          col_nxt    = '0;
          row_nxt    = '0;
          dcount_nxt = '0;
        end
      end else begin
        word_idx_nxt = word_idx_r + 7'd1;
      end
    end

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEXTURE_BASE: begin
          base_nxt     = cfg_data;
          word_idx_nxt = '0;
          col_nxt      = '0;
          row_nxt      = '0;
          dcount_nxt   = '0;
        end
        REG_BLOCKS_ACROSS: across_m1_nxt = cfg_data[GEOM_BITS-1:0];
        REG_BLOCKS_DOWN:   down_m1_nxt   = cfg_data[GEOM_BITS-1:0];
        REG_SINGLE_TILE:   single_nxt    = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      across_m1_r <= '0;
      down_m1_r   <= '0;
      single_r    <= 1'b0;
      word_idx_r  <= '0;
      col_r       <= '0;
      row_r       <= '0;
      dcount_r    <= '0;
      bank_r      <= 1'b0;
    end else begin
      base_r      <= base_nxt;
      across_m1_r <= across_m1_nxt;
      down_m1_r   <= down_m1_nxt;
      single_r    <= single_nxt;
      word_idx_r  <= word_idx_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      dcount_r    <= dcount_nxt;
      bank_r      <= bank_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/yuyv_jobq.sv
`default_nettype none
module yuyv_jobq import yuyv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  job_t q_job,
  output logic q_full,
  output logic q_valid,
  output job_t q_head,
  input  logic q_pop
);

  job_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign q_full  = (count_r == 2'd2);
  assign q_valid = (count_r != 2'd0);
  assign q_head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ q_push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + 2'(q_push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      entry_r[wr_ptr_r] <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/core/yuyv_back.sv
`default_nettype none
module yuyv_back import yuyv_pkg::*; #(
  parameter int VRAM_ADDR_BITS = 23
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mem_wr_t                   mem_wr,
  input  logic [BASE_BITS-1:0]      texture_base,
  input  logic                      q_valid,
  input  job_t                      q_head,
  output logic                      q_pop,
  output logic                      empty,
  input  logic                      pop,
  output logic [VRAM_ADDR_BITS-1:0] vram_address,
  output logic [63:0]               pixel_pair_data,
  output logic                      last_of_block,
  output logic                      texture_done,
  output logic [COUNT_BITS-1:0]     blocks_done
);

  localparam int A = VRAM_ADDR_BITS;

  logic [31:0] chroma_mem [2*CHROMA_WORDS];
  logic [31:0] luma_mem   [2*LUMA_WORDS];

  logic                  busy_r, busy_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic [A-1:0]          line_r;
  logic                  bank_r;
  logic [A-1:0]          stride_r;
  logic [COUNT_BITS-1:0] bd_r;
  logic                  done_r;

  logic                  s1_v_r;
  logic [A-1:0]          s1_addr_r;
  logic                  s1_last_r;
  logic                  s1_tdone_r;
  logic [COUNT_BITS-1:0] s1_bd_r;
  logic                  s1_sel_r;
  logic [31:0]           rd_u_r;
  logic [31:0]           rd_v_r;
  logic [31:0]           rd_y_r;

  logic [A-1:0]          fifo_addr  [2];
  logic [63:0]           fifo_data  [2];
  logic                  fifo_last  [2];
  logic                  fifo_tdone [2];
  logic [COUNT_BITS-1:0] fifo_bd    [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            occ_r, occ_nxt;

  logic         load;
  logic         issue;
  logic         pop_fire;
  logic [1:0]   pending;
  logic         last_issue;
  logic [3:0]   row;
  logic [1:0]   quad;
  logic [5:0]   u_idx;
  logic [5:0]   v_idx;
  logic [6:0]   y_idx;
  logic [A-1:0] base_ext;
  logic [A-1:0] base_al;
  logic [7:0]   u0, u1, v0, v1;
  logic [63:0]  s1_data;

  assign row   = cnt_r[5:2];
  assign quad  = cnt_r[1:0];
  assign u_idx = {bank_r, 1'b0, row[3:1], quad[1]};
  assign v_idx = {bank_r, 1'b1, row[3:1], quad[1]};
  assign y_idx = {bank_r, row[3], quad[1], row[2:0], quad[0]};

  assign base_ext = A'(texture_base);
  assign base_al  = {base_ext[A-1:3], 3'b000};

  assign pop_fire   = pop & (occ_r != 2'd0);
  assign pending    = occ_r + 2'(s1_v_r) - 2'(pop_fire);
  assign issue      = busy_r & (pending < 2'd2);
  assign last_issue = (cnt_r == 6'(WRITES_PER_BLOCK - 1));
  assign load       = ~busy_r & q_valid;
  assign q_pop      = issue & last_issue;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (issue) begin
      cnt_nxt = cnt_r + 6'd1;
      if (last_issue) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr.we && !mem_wr.luma) begin
      chroma_mem[{mem_wr.bank, mem_wr.addr[4:0]}] <= mem_wr.data;
    end
    if (mem_wr.we && mem_wr.luma) begin
      luma_mem[{mem_wr.bank, mem_wr.addr}] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_u_r <= chroma_mem[u_idx];
      rd_v_r <= chroma_mem[v_idx];
      rd_y_r <= luma_mem[y_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      line_r   <= base_al + A'(q_head.offset);
      bank_r   <= q_head.bank;
      stride_r <= A'(q_head.stride);
      bd_r     <= q_head.blocks_done;
      done_r   <= q_head.done;
    end else if (issue && quad == 2'd3) begin
      line_r <= line_r + stride_r;
    end
    if (issue) begin
      s1_addr_r  <= line_r + A'({quad, 3'b000});
      s1_last_r  <= last_issue;
      s1_tdone_r <= last_issue & done_r;
      s1_bd_r    <= bd_r;
      s1_sel_r   <= quad[0];
    end
  end

  always_comb begin
    u0 = s1_sel_r ? rd_u_r[23:16] : rd_u_r[7:0];
    u1 = s1_sel_r ? rd_u_r[31:24] : rd_u_r[15:8];
    v0 = s1_sel_r ? rd_v_r[23:16] : rd_v_r[7:0];
    v1 = s1_sel_r ? rd_v_r[31:24] : rd_v_r[15:8];
    s1_data = {rd_y_r[31:24], v1, rd_y_r[23:16], u1,
               rd_y_r[15:8],  v0, rd_y_r[7:0],   u0};
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      fifo_addr[wr_ptr_r]  <= s1_addr_r;
      fifo_data[wr_ptr_r]  <= s1_data;
      fifo_last[wr_ptr_r]  <= s1_last_r;
      fifo_tdone[wr_ptr_r] <= s1_tdone_r;
      fifo_bd[wr_ptr_r]    <= s1_bd_r;
    end
  end

  assign occ_nxt = occ_r + 2'(s1_v_r) - 2'(pop_fire);

  assign empty           = (occ_r == 2'd0);
  assign vram_address    = fifo_addr[rd_ptr_r];
  assign pixel_pair_data = fifo_data[rd_ptr_r];
  assign last_of_block   = fifo_last[rd_ptr_r];
  assign texture_done    = fifo_tdone[rd_ptr_r];
  assign blocks_done     = fifo_bd[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      s1_v_r   <= 1'b0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      occ_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      s1_v_r   <= issue;
      wr_ptr_r <= wr_ptr_r ^ s1_v_r;
      rd_ptr_r <= rd_ptr_r ^ pop_fire;
      occ_r    <= occ_nxt;
    end
  end

endmodule
`default_nettype wire

### tb/sv/tb_yuv420_macroblock_to_yuyv.sv
`timescale 1ns / 100ps
module tb_yuv420_macroblock_to_yuyv;
  import yuyv_pkg::*;

  localparam int ADDR_BITS   = BASE_BITS;
  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_WORDS  = 410;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [ADDR_BITS-1:0]  addr;
    logic [63:0]           pixels;
    logic                  last;
    logic                  done;
    logic [COUNT_BITS-1:0] count;
  } vram_write_t;

  typedef enum logic {ROW_REG, ROW_WORDS} row_kind_t;
  typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  typedef struct {
    row_kind_t                kind;
    cfg_reg_t                 target;
    logic [CFG_DATA_BITS-1:0] value;
    int unsigned              words;
    fill_t                    fill;
    bit                       pinned;
    logic [63:0]              pixels;
  } plan_row_t;

  logic                      clk            = 1'b0;
  logic                      rst_n          = 1'b0;
  logic                      cfg_we         = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index      = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data       = '0;
  logic                      push           = 1'b0;
  logic [31:0]               in_stream_word = '0;
  logic                      pop            = 1'b0;
  logic                      full;
  logic                      empty;
  logic [ADDR_BITS-1:0]      out_vram_address;
  logic [63:0]               out_pixel_pair_data;
  logic                      out_last_of_block;
  logic                      out_texture_done;
  logic [COUNT_BITS-1:0]     out_blocks_done;

  always #4 clk = ~clk;

  yuv420_macroblock_to_yuyv #(
    .VRAM_ADDR_BITS(ADDR_BITS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .push               (push),
    .full               (full),
    .in_stream_word     (in_stream_word),
    .empty              (empty),
    .pop                (pop),
    .out_vram_address   (out_vram_address),
    .out_pixel_pair_data(out_pixel_pair_data),
    .out_last_of_block  (out_last_of_block),
    .out_texture_done   (out_texture_done),
    .out_blocks_done    (out_blocks_done)
  );

  logic [31:0]           mb_words [BLOCK_WORDS];
  int unsigned           fill_pos          = 0;
  int unsigned           tile_col          = 0;
  int unsigned           tile_row          = 0;
  logic [COUNT_BITS-1:0] blocks_in_texture = '0;
  logic [ADDR_BITS-1:0]  tex_base          = '0;
  logic [GEOM_BITS-1:0]  across_m1         = '0;
  logic [GEOM_BITS-1:0]  down_m1           = '0;
  logic                  single_tile       = 1'b0;

  vram_write_t writes_due[$];
  plan_row_t   plan[$];

  int          words_taken     = 0;
  int          words_sent      = 0;
  int          burst_left      = 0;
  int          idle_cycles     = 0;
  int          mismatches      = 0;
  int          writes_checked  = 0;
  int          blocks_expected = 0;
  int          textures_closed = 0;
  int          reg_writes      = 0;
  int          restarts        = 0;
  bit          pin_on          = 1'b0;
  logic [63:0] pin_pixels      = '0;

  function automatic logic [7:0] mb_byte(int unsigned i);
    return mb_words[(i >> 2) % BLOCK_WORDS][(i % 4) * 8 +: 8];
  endfunction

  function automatic logic [7:0] luma_at(int unsigned x, int unsigned y);
    int unsigned off;
    off = 128;
    if (x > 7) begin
      x -= 8;
      off += 64;
    end
    if (y > 7) begin
      y -= 8;
      off += 128;
    end
    return mb_byte(off + x + y * 8);
  endfunction

  function automatic logic [7:0] chroma_at(int unsigned plane, int unsigned x, int unsigned y);
    return mb_byte(plane + (x >> 1) + (y >> 1) * 8);
  endfunction

  function automatic logic [31:0] yuyv_at(int unsigned x, int unsigned y);
    return {luma_at(x + 1, y), chroma_at(64, x, y), luma_at(x, y), chroma_at(0, x, y)};
  endfunction

  function automatic void restart_texture();
    fill_pos          = 0;
    tile_col          = 0;
    tile_row          = 0;
    blocks_in_texture = '0;
  endfunction

  function automatic void take_reg_write(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] val);
    case (cfg_reg_t'(idx))
      REG_TEXTURE_BASE: begin
        tex_base = val[ADDR_BITS-1:0];
        restart_texture();
      end
      REG_BLOCKS_ACROSS: across_m1   = val[GEOM_BITS-1:0];
      REG_BLOCKS_DOWN:   down_m1     = val[GEOM_BITS-1:0];
      REG_SINGLE_TILE:   single_tile = val[0];
      default: ;
    endcase
    reg_writes++;
  endfunction

  function automatic void gather_word(logic [31:0] w);
    int unsigned          across, down, total, width, tx, ty, x, y, n;
    logic [ADDR_BITS-1:0] base;
    logic                 done;
    vram_write_t          wr;
    if (fill_pos >= BLOCK_WORDS) fill_pos = 0;
    mb_words[fill_pos] = w;
    fill_pos++;
    if (fill_pos < BLOCK_WORDS) return;
    fill_pos = 0;

    across = across_m1 + 1;
    down   = down_m1 + 1;
    total  = across * down;
    blocks_in_texture = blocks_in_texture + 1'b1;
    done = (blocks_in_texture >= total);
    if (single_tile) begin
      width = 16;
      tx    = 0;
      ty    = 0;
    end else begin
      width = across * 16;
      if (tile_col >= across) tile_col = 0;
      if (tile_row >= down) tile_row = 0;
      tx = tile_col * 16;
      ty = tile_row * 16;
    end
    base = {tex_base[ADDR_BITS-1:3], 3'b000};

    n = 0;
    for (y = 0; y < 16; y++) begin
      for (x = 0; x < 16; x += 4) begin
        wr.addr   = base + ADDR_BITS'(((tx + x) + (ty + y) * width) * 2);
        wr.pixels = pin_on ? pin_pixels : {yuyv_at(x + 2, y), yuyv_at(x, y)};
        wr.last   = (n == WRITES_PER_BLOCK - 1);
        wr.done   = wr.last && done;
        wr.count  = blocks_in_texture;
        writes_due.push_back(wr);
        n++;
      end
    end
    blocks_expected++;

    if (!single_tile) begin
      tile_col++;
      if (tile_col >= across) begin
        tile_col = 0;
        tile_row++;
        if (tile_row >= down) tile_row = 0;
      end
    end
    if (done) begin
      textures_closed++;
      restart_texture();
    end
  endfunction

  function automatic void check_write();
    vram_write_t want;
    if (writes_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected VRAM write: addr %h data %h last %b done %b count %0d",
                 out_vram_address, out_pixel_pair_data, out_last_of_block,
                 out_texture_done, out_blocks_done);
      return;
    end
    want = writes_due.pop_front();
    writes_checked++;
    if (out_vram_address !== want.addr || out_pixel_pair_data !== want.pixels ||
        out_last_of_block !== want.last || out_texture_done !== want.done ||
        out_blocks_done !== want.count) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("write %0d (exp/got): addr %h/%h data %h/%h last %b/%b done %b/%b cnt %0d/%0d",
                 writes_checked, want.addr, out_vram_address, want.pixels,
                 out_pixel_pair_data, want.last, out_last_of_block, want.done,
                 out_texture_done, want.count, out_blocks_done);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tex_base    = '0;
      across_m1   = '0;
      down_m1     = '0;
      single_tile = 1'b0;
      restart_texture();
      idle_cycles <= 0;
    end else begin
      if (cfg_we) take_reg_write(cfg_index, cfg_data);
      if (push && !full) begin
        gather_word(in_stream_word);
        words_taken <= words_taken + 1;
      end
      if (pop && !empty) check_write();
      if (cfg_we || (push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  logic [15:0] pop_mask = 16'hFFFF;
  logic [7:0]  pop_tick = '0;

  function automatic logic [15:0] next_pop_mask();
    case ($urandom_range(0, 3))
      0:       return 16'hFFFF;
      1:       return 16'($urandom) | 16'h0001;
      2:       return 16'($urandom & $urandom & $urandom) | 16'h0001;
      default: return ~(16'h0001 << $urandom_range(1, 15));
    endcase
  endfunction

  always @(negedge clk) begin
    pop_tick <= pop_tick + 1'b1;
    if (pop_tick == 8'hFF) pop_mask <= next_pop_mask();
    pop <= pop_mask[pop_tick[3:0]];
  end

  function automatic void plan_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
    plan_row_t row;
    row = '{ROW_REG, r, v, 0, FILL_RANDOM, 1'b0, 64'h0};
    plan.push_back(row);
  endfunction

  function automatic void plan_words(int unsigned n, fill_t f, bit pinned, logic [63:0] pix);
    plan_row_t row;
    row = '{ROW_WORDS, REG_TEXTURE_BASE, '0, n, f, pinned, pix};
    plan.push_back(row);
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_geom();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return CFG_DATA_BITS'(63);
      default: return CFG_DATA_BITS'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] random_base();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return CFG_DATA_BITS'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [31:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    words_sent++;
    push           <= 1'b1;
    in_stream_word <= w;
    do @(negedge clk); while (words_taken != words_sent);
  endtask

  task automatic send_words(int unsigned n, fill_t f);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      case (f)
        FILL_ZERO: send_word(32'h0);
        FILL_ONES: send_word(32'hFFFF_FFFF);
        default:   send_word($urandom);
      endcase
    end
  endtask

  // hold the stream until every write is out, then let the pipeline settle
  task automatic settle();
    push <= 1'b0;
    burst_left = 0;
    while (writes_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_BITS-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    plan_row_t   row;
    int unsigned part;

    plan_words(BLOCK_WORDS, FILL_ZERO, 1'b1, 64'h0);
    plan_reg(REG_BLOCKS_ACROSS, 63);
    plan_reg(REG_BLOCKS_DOWN, 63);
    plan_reg(REG_TEXTURE_BASE, 23'h7FFFF8);
    plan_words(8, FILL_RANDOM, 1'b0, 64'h0);
    // drop the partial block, unaligned base at the top of VRAM
    plan_reg(REG_TEXTURE_BASE, 23'h7FFFFF);
    plan_words(BLOCK_WORDS, FILL_ONES, 1'b1, '1);
    // shrink the texture to one tile under a live count
    plan_reg(REG_BLOCKS_ACROSS, 0);
    plan_reg(REG_BLOCKS_DOWN, 0);
    plan_reg(REG_SINGLE_TILE, 1);
    plan_words(BLOCK_WORDS, FILL_RANDOM, 1'b0, 64'h0);
    plan_reg(REG_SINGLE_TILE, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_REG) begin
        settle();
        write_reg(row.target, row.value);
      end else begin
        pin_on     = row.pinned;
        pin_pixels = row.pixels;
        send_words(row.words, row.fill);
        pin_on     = 1'b0;
      end
    end

    while (words_sent < ITEM_WORDS) begin
      settle();
      if ($urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, BLOCK_WORDS - 1);
        if (part > unsigned'(ITEM_WORDS - words_sent)) part = unsigned'(ITEM_WORDS - words_sent);
        send_words(part, FILL_RANDOM);
        settle();
        write_reg(REG_TEXTURE_BASE, random_base());
        restarts++;
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_BLOCKS_ACROSS, random_geom());
      if ($urandom_range(0, 3) != 0) write_reg(REG_BLOCKS_DOWN, random_geom());
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_SINGLE_TILE, CFG_DATA_BITS'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 0) write_reg(REG_TEXTURE_BASE, random_base());
      part = BLOCK_WORDS - fill_pos + $urandom_range(0, 1) * BLOCK_WORDS;
      if (part > unsigned'(ITEM_WORDS - words_sent)) part = unsigned'(ITEM_WORDS - words_sent);
      send_words(part, FILL_RANDOM);
    end

    settle();
    repeat (8) @(negedge clk);
    mismatches += writes_due.size();

    $display("Converted %0d macroblocks into %0d checked VRAM writes, %0d textures closed.",
             blocks_expected, writes_checked, textures_closed);
    $display("Stream words: %0d, register writes: %0d, restarts over partial blocks: %0d.",
             words_sent, reg_writes, restarts);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### yuv420_macroblock_to_yuyv.f
rtl/core/yuyv_pkg.sv
rtl/core/yuyv_front.sv
rtl/core/yuyv_jobq.sv
rtl/core/yuyv_back.sv
rtl/core/yuv420_macroblock_to_yuyv.sv
tb/sv/tb_yuv420_macroblock_to_yuyv.sv
